/* src/inactivity_reminder_timer_defines.svh */
// Assertion macros used by the checker of the inactivity reminder timer.
`ifndef INACTIVITY_REMINDER_TIMER_DEFINES_SVH
`define INACTIVITY_REMINDER_TIMER_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define IRT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define IRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked during reset.
`define IRT_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* src/irt_pkg.sv */
`default_nettype none

package irt_pkg;

    // Depth of the step history, in minutes.
    localparam int WINDOW_MINUTES = 5;
    // Width of the history fill count, which must hold the depth itself.
    localparam int FILL_W = $clog2(WINDOW_MINUTES + 1);

    localparam int STEP_W  = 16;
    localparam int COUNT_W = 8;

    // Idle rules.
    localparam logic [STEP_W-1:0]  IDLE_STEP_LIMIT = 16'd13;
    localparam logic [COUNT_W-1:0] IDLE_COUNT_MAX  = 8'd245;

    // Wear detector states that count as worn.
    localparam logic [7:0] WEAR_WORN_BELOW = 8'd2;
    localparam logic [7:0] WEAR_WORN_ALT   = 8'd5;

    // Request commands.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_INIT = 1'b1;

    // Configuration register map.
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_ENABLE        = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_START_HOUR    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_START_MINUTE  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_END_HOUR      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_END_MINUTE    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ALERT_MINUTES = 3'd5;

    // Register reset values.
    localparam logic [4:0] RST_START_HOUR    = 5'd8;
    localparam logic [5:0] RST_START_MINUTE  = 6'd0;
    localparam logic [4:0] RST_END_HOUR      = 5'd18;
    localparam logic [5:0] RST_END_MINUTE    = 6'd0;
    localparam logic [7:0] RST_ALERT_MINUTES = 8'd60;

    typedef struct packed {
        logic       enable;
        logic [4:0] start_hour;
        logic [5:0] start_minute;
        logic [4:0] end_hour;
        logic [5:0] end_minute;
        logic [7:0] alert_minutes;
    } t_cfg;

    typedef struct packed {
        logic        command;
        logic [31:0] total_steps;
        logic [4:0]  hour_now;
        logic [5:0]  minute_now;
        logic        signed_off;
        logic        sleeping;
        logic        power_ok;
        logic [7:0]  wear_state;
    } t_in_item;

    typedef struct packed {
        logic               alert;
        logic [COUNT_W-1:0] idle_count;
        logic [STEP_W-1:0]  recent_steps;
    } t_out_item;

endpackage

`default_nettype wire

/* src/inactivity_reminder_timer.sv */
`default_nettype none

// Inactivity reminder timer: feed one request per minute (a tick, or an init that restarts
// the bookkeeping) and take one result per request. The block accepts a request in every
// cycle unless both registers are full and the output side stalls; a request waits in the
// input register, then the history update, the five-entry sum and the idle-count compare
// run in a single combinational pass into the result register. The result register and
// the input register together let a new request enter while a result still waits. Program
// the window, the threshold and the enable through the register port only while no request
// is in flight.
module inactivity_reminder_timer import irt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data
);

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item core_result;
    logic      out_free;
    logic      core_fire;
    logic      in_accept;

    assign reg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable        <= 1'b0;
            r_cfg.start_hour    <= RST_START_HOUR;
            r_cfg.start_minute  <= RST_START_MINUTE;
            r_cfg.end_hour      <= RST_END_HOUR;
            r_cfg.end_minute    <= RST_END_MINUTE;
            r_cfg.alert_minutes <= RST_ALERT_MINUTES;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_ENABLE: begin
                    r_cfg.enable <= pwdata[0];
                end
                REG_START_HOUR: begin
                    r_cfg.start_hour <= pwdata[4:0];
                end
                REG_START_MINUTE: begin
                    r_cfg.start_minute <= pwdata[5:0];
                end
                REG_END_HOUR: begin
                    r_cfg.end_hour <= pwdata[4:0];
                end
                REG_END_MINUTE: begin
                    r_cfg.end_minute <= pwdata[5:0];
                end
                REG_ALERT_MINUTES: begin
                    r_cfg.alert_minutes <= pwdata[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (reg_idx)
            REG_ENABLE:        prdata = 32'(r_cfg.enable);
            REG_START_HOUR:    prdata = 32'(r_cfg.start_hour);
            REG_START_MINUTE:  prdata = 32'(r_cfg.start_minute);
            REG_END_HOUR:      prdata = 32'(r_cfg.end_hour);
            REG_END_MINUTE:    prdata = 32'(r_cfg.end_minute);
            REG_ALERT_MINUTES: prdata = 32'(r_cfg.alert_minutes);
            default:           prdata = '0;
        endcase
    end

    // Handshake: a request moves on when the result register is free or being drained.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign core_fire  = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (core_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_data;
        end
    end

    irt_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (core_fire),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_fire) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* src/irt_core.sv */
`default_nettype none

module irt_core import irt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    logic [STEP_W-1:0]  r_hist [WINDOW_MINUTES];
    logic [STEP_W-1:0]  n_hist [WINDOW_MINUTES];
    logic [FILL_W-1:0]  r_fill;
    logic [FILL_W-1:0]  n_fill;
    logic [STEP_W-1:0]  r_last_total;
    logic [STEP_W-1:0]  n_last_total;
    logic [COUNT_W-1:0] r_idle;
    logic [COUNT_W-1:0] n_idle;

    logic [STEP_W-1:0]  delta;
    logic [10:0]        now_key;
    logic               gates;
    logic               in_window;
    logic               qualify;
    logic               is_init;
    logic [STEP_W-1:0]  sum;
    logic [COUNT_W-1:0] idle_step;
    logic               alert;

    // Gating flags and the monitoring window, compared hour first.
    assign now_key   = {i_item.hour_now, i_item.minute_now};
    assign gates     = !i_item.signed_off && !i_item.sleeping && i_item.power_ok &&
                       ((i_item.wear_state < WEAR_WORN_BELOW) ||
                        (i_item.wear_state == WEAR_WORN_ALT)) && i_cfg.enable;
    assign in_window = (now_key >= {i_cfg.start_hour, i_cfg.start_minute}) &&
                       (now_key <= {i_cfg.end_hour, i_cfg.end_minute});
    assign is_init   = (i_item.command == CMD_INIT);
    assign qualify   = !is_init && gates && in_window;

    // Only the low half of the running total matters for a 16-bit delta.
    assign delta = i_item.total_steps[STEP_W-1:0] - r_last_total;

    // History update: cleared by an init; fill from the front, then shift toward the front.
    always_comb begin
        n_hist       = r_hist;
        n_fill       = r_fill;
        n_last_total = r_last_total;
        if (is_init) begin
            for (int i = 0; i < WINDOW_MINUTES; i++) begin
                n_hist[i] = '0;
            end
            n_fill       = '0;
            n_last_total = i_item.total_steps[STEP_W-1:0];
        end else if (qualify) begin
            if (r_fill < FILL_W'(WINDOW_MINUTES)) begin
                for (int i = 0; i < WINDOW_MINUTES; i++) begin
                    if (r_fill == FILL_W'(i)) begin
                        n_hist[i] = delta;
                    end
                end
                n_fill = r_fill + FILL_W'(1);
            end else begin
                for (int i = 0; i < WINDOW_MINUTES - 1; i++) begin
                    n_hist[i] = r_hist[i + 1];
                end
                n_hist[WINDOW_MINUTES-1] = delta;
            end
            n_last_total = i_item.total_steps[STEP_W-1:0];
        end
    end

    // Sum of the updated history, wrapping at 16 bits.
    always_comb begin
        sum = '0;
        for (int i = 0; i < WINDOW_MINUTES; i++) begin
            sum = sum + n_hist[i];
        end
    end

    // Idle counter with saturation and the alert at the threshold.
    assign idle_step = (r_idle < IDLE_COUNT_MAX) ? (r_idle + COUNT_W'(1)) : r_idle;

    always_comb begin
        n_idle = '0;
        alert  = 1'b0;
        if (qualify && (sum < IDLE_STEP_LIMIT)) begin
            if (idle_step >= i_cfg.alert_minutes) begin
                alert = 1'b1;
            end else begin
                n_idle = idle_step;
            end
        end
    end

    assign o_result.alert        = alert;
    assign o_result.idle_count   = n_idle;
    assign o_result.recent_steps = sum;

    // State registers advance once per processed request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_MINUTES; i++) begin
                r_hist[i] <= '0;
            end
            r_fill       <= '0;
            r_last_total <= '0;
            r_idle       <= '0;
        end else if (i_fire) begin
            r_hist       <= n_hist;
            r_fill       <= n_fill;
            r_last_total <= n_last_total;
            r_idle       <= n_idle;
        end
    end

endmodule

`default_nettype wire

/* src/irt_checker.sv */
`default_nettype none

`include "inactivity_reminder_timer_defines.svh"

module irt_checker import irt_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input t_out_item         o_out_data
);

    // A stalled result stays valid and unchanged.
    `IRT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result changed")

    // The alert always comes with a cleared idle count.
    `IRT_ASSERT_IMPLY(a_alert_clears, i_clk, i_rst_n, o_out_valid && o_out_data.alert, o_out_data.idle_count == '0, "alert with nonzero idle count")

    // The idle count never passes its saturation value.
    `IRT_ASSERT_IMPLY(a_idle_sat, i_clk, i_rst_n, o_out_valid, o_out_data.idle_count <= IDLE_COUNT_MAX, "idle count above saturation")

    // Reset empties the result register.
    `IRT_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid, "result valid after reset")

endmodule

bind inactivity_reminder_timer irt_checker u_irt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire

/* test/testbench.sv */
`default_nettype none

module testbench;
    import irt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 4;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 3000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    t_in_item          i_in_data = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_item         o_out_data;

    inactivity_reminder_timer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Requests waiting to be driven and results predicted for accepted requests.
    t_in_item  waiting_requests[$];
    t_out_item predicted_results[$];

    // Shadow of the configuration registers and of the block's bookkeeping.
    t_cfg        cfg_shadow = '{enable: 1'b0, start_hour: RST_START_HOUR,
                                start_minute: RST_START_MINUTE, end_hour: RST_END_HOUR,
                                end_minute: RST_END_MINUTE, alert_minutes: RST_ALERT_MINUTES};
    logic [15:0] step_hist[WINDOW_MINUTES] = '{default: '0};
    int          hist_fill = 0;
    logic [31:0] prev_total = '0;
    logic [7:0]  idle_minutes = '0;

    // Stimulus knobs, written by the sequencing block only.
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_requests = 0;
    logic [31:0] gen_total = '0;

    // Run state and statistics.
    logic in_taken = 1'b0;
    int   holds_served = 0;
    int   hold_left = 0;
    int   errors = 0;
    int   n_requests = 0;
    int   n_inits = 0;
    int   n_results = 0;
    int   n_alerts = 0;
    int   n_saturated = 0;
    int   n_settings = 0;
    int   n_in_stalls = 0;
    int   quiet_cycles = 0;

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("MISMATCH at %0t, %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Works out the result of one request and advances the shadow state.
    function automatic t_out_item predict_reminder(input t_in_item req);
        t_out_item   res;
        logic [10:0] now_key;
        logic [10:0] open_key;
        logic [10:0] close_key;
        logic [15:0] sum;
        logic        gates;
        res = '0;
        if (req.command == CMD_INIT) begin
            step_hist = '{default: '0};
            hist_fill = 0;
            idle_minutes = '0;
            prev_total = req.total_steps;
            return res;
        end
        gates = !req.signed_off && !req.sleeping && req.power_ok && cfg_shadow.enable &&
                (req.wear_state < WEAR_WORN_BELOW || req.wear_state == WEAR_WORN_ALT);
        now_key = {req.hour_now, req.minute_now};
        open_key = {cfg_shadow.start_hour, cfg_shadow.start_minute};
        close_key = {cfg_shadow.end_hour, cfg_shadow.end_minute};
        if (gates && now_key >= open_key && now_key <= close_key) begin
            // Qualifying minute: record the truncated step delta.
            if (hist_fill < WINDOW_MINUTES) begin
                step_hist[hist_fill] = req.total_steps[15:0] - prev_total[15:0];
                hist_fill++;
            end else begin
                for (int i = 0; i < WINDOW_MINUTES - 1; i++) step_hist[i] = step_hist[i + 1];
                step_hist[WINDOW_MINUTES - 1] = req.total_steps[15:0] - prev_total[15:0];
            end
            prev_total = req.total_steps;
        end else begin
            gates = 1'b0;
            idle_minutes = '0;
        end
        sum = '0;
        for (int i = 0; i < WINDOW_MINUTES; i++) sum += step_hist[i];
        if (gates) begin
            if (sum < IDLE_STEP_LIMIT) begin
                if (idle_minutes < IDLE_COUNT_MAX) idle_minutes++;
                if (idle_minutes >= cfg_shadow.alert_minutes) begin
                    idle_minutes = '0;
                    res.alert = 1'b1;
                end
            end else begin
                idle_minutes = '0;
            end
        end
        res.idle_count = idle_minutes;
        res.recent_steps = sum;
        return res;
    endfunction

    function automatic t_in_item mk_item(input logic cmd, input logic [31:0] total,
                                         input logic [4:0] hour, input logic [5:0] minute,
                                         input logic off, input logic asleep,
                                         input logic pwr_ok, input logic [7:0] wear);
        t_in_item req;
        req.command = cmd;
        req.total_steps = total;
        req.hour_now = hour;
        req.minute_now = minute;
        req.signed_off = off;
        req.sleeping = asleep;
        req.power_ok = pwr_ok;
        req.wear_state = wear;
        return req;
    endfunction

    // Mostly plausible minute ticks, inside the window unless it is inverted; the rest is noise,
    // ticks with one gate broken, and init commands.
    function automatic t_in_item make_request(input int noise_pct, input int init_pct,
                                              input int busy_pct);
        t_in_item    req;
        logic [10:0] open_key;
        logic [10:0] close_key;
        logic [10:0] key;
        int          roll;
        open_key = {cfg_shadow.start_hour, cfg_shadow.start_minute};
        close_key = {cfg_shadow.end_hour, cfg_shadow.end_minute};
        roll = $urandom_range(0, 99);
        if (roll < init_pct) begin
            if ($urandom_range(0, 1)) gen_total = $urandom;
            return mk_item(CMD_INIT, gen_total, 5'($urandom_range(0, 31)),
                           6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           8'($urandom_range(0, 255)));
        end
        if (roll < init_pct + noise_pct / 2) begin
            return mk_item(CMD_TICK, $urandom, 5'($urandom_range(0, 31)),
                           6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           8'($urandom_range(0, 255)));
        end
        // Step count since the previous minute: mostly idle, sometimes busy.
        if ($urandom_range(0, 99) < busy_pct) begin
            if ($urandom_range(0, 9) == 0) gen_total += $urandom;
            else gen_total += $urandom_range(13, 500);
        end else begin
            gen_total += $urandom_range(0, 2);
        end
        if (open_key <= close_key) key = 11'($urandom_range(open_key, close_key));
        else key = 11'($urandom_range(0, 2047));
        req = mk_item(CMD_TICK, gen_total, key[10:6], key[5:0], 1'b0, 1'b0, 1'b1, 8'd0);
        case ($urandom_range(0, 2))
            0: req.wear_state = 8'd0;
            1: req.wear_state = 8'd1;
            default: req.wear_state = WEAR_WORN_ALT;
        endcase
        if (roll < init_pct + noise_pct) begin
            case ($urandom_range(0, 3))
                0: req.signed_off = 1'b1;
                1: req.sleeping = 1'b1;
                2: req.power_ok = 1'b0;
                default: begin
                    req.wear_state = 8'($urandom_range(2, 255));
                    if (req.wear_state == WEAR_WORN_ALT) req.wear_state = 8'd6;
                end
            endcase
        end
        return req;
    endfunction

    // Register write followed by a readback, both on the idle block.
    task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        logic [31:0] width_mask;
        logic [31:0] readback;
        case (idx)
            REG_ENABLE: begin
                cfg_shadow.enable = value[0];
                width_mask = 32'h1;
            end
            REG_START_HOUR: begin
                cfg_shadow.start_hour = value[4:0];
                width_mask = 32'h1f;
            end
            REG_START_MINUTE: begin
                cfg_shadow.start_minute = value[5:0];
                width_mask = 32'h3f;
            end
            REG_END_HOUR: begin
                cfg_shadow.end_hour = value[4:0];
                width_mask = 32'h1f;
            end
            REG_END_MINUTE: begin
                cfg_shadow.end_minute = value[5:0];
                width_mask = 32'h3f;
            end
            default: begin
                cfg_shadow.alert_minutes = value[7:0];
                width_mask = 32'hff;
            end
        endcase
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        readback = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if ((readback & width_mask) !== (value & width_mask))
            report_mismatch($sformatf("register %0d readback", idx), 64'(readback & width_mask),
                            64'(value & width_mask));
    endtask

    // Waits until every request is accepted and every result has come back.
    task automatic drain();
        do @(negedge i_clk);
        while (waiting_requests.size() != 0 || i_in_valid || predicted_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_phase(input int count, input int noise_pct, input int init_pct,
                             input int busy_pct, input int s_idle, input int r_stall);
        send_idle_pct = s_idle;
        stall_pct = r_stall;
        n_settings++;
        repeat (count) waiting_requests.push_back(make_request(noise_pct, init_pct, busy_pct));
        drain();
    endtask

    // Sender: offers the next request whenever the current one was taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (waiting_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_data <= waiting_requests.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left <= HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Acceptance, result checking and the watchdog.
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        logic      progress;
        progress = 1'b0;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            predicted_results.push_back(predict_reminder(i_in_data));
            n_requests++;
            if (i_in_data.command == CMD_INIT) n_inits++;
            in_taken <= 1'b1;
            progress = 1'b1;
        end else begin
            in_taken <= 1'b0;
        end
        if (i_rst_n && i_in_valid && o_in_stall && hold_left != 0) n_in_stalls++;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            progress = 1'b1;
            n_results++;
            if (predicted_results.size() == 0) begin
                report_mismatch("result with no request outstanding", 1, 0);
            end else begin
                want = predicted_results.pop_front();
                if (o_out_data.alert !== want.alert)
                    report_mismatch("alert", 64'(o_out_data.alert), 64'(want.alert));
                if (o_out_data.idle_count !== want.idle_count)
                    report_mismatch("idle_count", 64'(o_out_data.idle_count),
                                    64'(want.idle_count));
                if (o_out_data.recent_steps !== want.recent_steps)
                    report_mismatch("recent_steps", 64'(o_out_data.recent_steps),
                                    64'(want.recent_steps));
                if (want.alert) n_alerts++;
                if (want.idle_count == IDLE_COUNT_MAX) n_saturated++;
            end
        end
        if (progress || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Watchdog expired after %0d cycles without progress.", QUIET_LIMIT);
                $display("inactivity_reminder_timer verification failed");
                $finish;
            end
        end
    end

    // Test sequence.
    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // Reset settings, reminder off: nothing qualifies.
        n_settings++;
        waiting_requests.push_back(mk_item(CMD_TICK, 32'd100, 5'd9, 6'd0, 0, 0, 1, 8'd0));
        waiting_requests.push_back(mk_item(CMD_INIT, 32'd0, 5'd9, 6'd1, 0, 0, 1, 8'd0));
        waiting_requests.push_back(mk_item(CMD_TICK, 32'd3, 5'd9, 6'd2, 0, 0, 1, 8'd1));
        drain();

        // Whole day open, short threshold; directed corner cases.
        cfg_write(REG_ENABLE, 32'd1);
        cfg_write(REG_START_HOUR, 32'd0);
        cfg_write(REG_START_MINUTE, 32'd0);
        cfg_write(REG_END_HOUR, 32'd23);
        cfg_write(REG_END_MINUTE, 32'd59);
        cfg_write(REG_ALERT_MINUTES, 32'd3);
        n_settings++;
        waiting_requests.push_back(mk_item(CMD_INIT, 32'd1000, 5'd0, 6'd0, 0, 0, 1, 8'd0));
        // Window edges, then the third idle minute raises the alert.
        waiting_requests.push_back(mk_item(CMD_TICK, 32'd1000, 5'd0, 6'd0, 0, 0, 1, 8'd0));
        waiting_requests.push_back(mk_item(CMD_TICK, 32'd1005, 5'd23, 6'd59, 0, 0, 1, 8'd1));
        waiting_requests.push_back(mk_item(CMD_TICK, 32'd1007, 5'd12, 6'd0, 0, 0, 1, 8'd5));
        waiting_requests.push_back(mk_item(CMD_TICK, 32'd1020, 5'd12, 6'd1, 0, 0, 1, 8'd1));
        // Each gate broken on its own.
        waiting_requests.push_back(mk_item(CMD_TICK, 32'd1020, 5'd12, 6'd2, 1, 0, 1, 8'd0));
        waiting_requests.push_back(mk_item(CMD_TICK, 32'd1020, 5'd12, 6'd3, 0, 1, 1, 8'd0));
        waiting_requests.push_back(mk_item(CMD_TICK, 32'd1020, 5'd12, 6'd4, 0, 0, 0, 8'd0));
        waiting_requests.push_back(mk_item(CMD_TICK, 32'd1020, 5'd12, 6'd5, 0, 0, 1, 8'd2));
        waiting_requests.push_back(mk_item(CMD_TICK, 32'd1020, 5'd12, 6'd6, 0, 0, 1, 8'd4));
        waiting_requests.push_back(mk_item(CMD_TICK, 32'd1020, 5'd12, 6'd7, 0, 0, 1, 8'd5));
        waiting_requests.push_back(mk_item(CMD_TICK, 32'd1020, 5'd12, 6'd8, 0, 0, 1, 8'd255));
        // Out-of-range times fall past the end of the window.
        waiting_requests.push_back(mk_item(CMD_TICK, 32'd1020, 5'd31, 6'd63, 0, 0, 1, 8'd0));
        waiting_requests.push_back(mk_item(CMD_TICK, 32'd1020, 5'd24, 6'd0, 0, 0, 1, 8'd0));
        waiting_requests.push_back(mk_item(CMD_TICK, 32'd0, 5'd23, 6'd60, 0, 0, 1, 8'd0));
        // Total extremes, delta truncation and wraparound with a full history.
        waiting_requests.push_back(mk_item(CMD_TICK, 32'hffff_ffff, 5'd13, 6'd0, 0, 0, 1, 8'd0));
        waiting_requests.push_back(mk_item(CMD_TICK, 32'h0000_0003, 5'd13, 6'd1, 0, 0, 1, 8'd0));
        waiting_requests.push_back(mk_item(CMD_TICK, 32'h8000_0000, 5'd13, 6'd2, 0, 0, 1, 8'd1));
        waiting_requests.push_back(mk_item(CMD_INIT, 32'hffff_fff0, 5'd31, 6'd63, 1, 1, 0,
                                           8'd255));
        waiting_requests.push_back(mk_item(CMD_TICK, 32'h0000_0005, 5'd14, 6'd0, 0, 0, 1, 8'd0));
        waiting_requests.push_back(mk_item(CMD_TICK, 32'h0000_0005, 5'd14, 6'd1, 0, 0, 1, 8'd0));
        gen_total = 32'h0000_0005;
        drain();
        run_phase(300, 10, 2, 15, 0, 0);

        // Daytime window, threshold zero: every idle minute alerts.
        cfg_write(REG_START_HOUR, 32'd8);
        cfg_write(REG_START_MINUTE, 32'd30);
        cfg_write(REG_END_HOUR, 32'd17);
        cfg_write(REG_END_MINUTE, 32'd45);
        cfg_write(REG_ALERT_MINUTES, 32'd0);
        run_phase(250, 15, 3, 30, 63, 0);

        // Widest window and top threshold: the idle count saturates.
        cfg_write(REG_START_HOUR, 32'd0);
        cfg_write(REG_START_MINUTE, 32'd0);
        cfg_write(REG_END_HOUR, 32'd31);
        cfg_write(REG_END_MINUTE, 32'd63);
        cfg_write(REG_ALERT_MINUTES, 32'd255);
        run_phase(300, 0, 0, 0, 0, 63);

        // Inverted window: no tick qualifies.
        cfg_write(REG_START_HOUR, 32'd31);
        cfg_write(REG_START_MINUTE, 32'd63);
        cfg_write(REG_END_HOUR, 32'd0);
        cfg_write(REG_END_MINUTE, 32'd0);
        cfg_write(REG_ALERT_MINUTES, 32'd5);
        run_phase(150, 20, 3, 20, 20, 20);

        // One-minute window with the receiver holding off so the block backs up.
        cfg_write(REG_START_HOUR, 32'd12);
        cfg_write(REG_START_MINUTE, 32'd0);
        cfg_write(REG_END_HOUR, 32'd12);
        cfg_write(REG_END_MINUTE, 32'd0);
        cfg_write(REG_ALERT_MINUTES, 32'd1);
        hold_requests = hold_requests + 1;
        run_phase(200, 10, 2, 20, 0, 0);

        // Reminder off again.
        cfg_write(REG_ENABLE, 32'd0);
        cfg_write(REG_END_HOUR, 32'd23);
        cfg_write(REG_END_MINUTE, 32'd59);
        cfg_write(REG_START_HOUR, 32'd0);
        cfg_write(REG_ALERT_MINUTES, 32'd245);
        run_phase(150, 20, 3, 20, 20, 20);

        // Back on at the saturation threshold.
        cfg_write(REG_ENABLE, 32'd1);
        run_phase(250, 10, 1, 5, 0, 63);

        repeat (10) @(negedge i_clk);
        $display("Covered %0d requests (%0d init) over %0d register settings, %0d results.",
                 n_requests, n_inits, n_settings, n_results);
        $display("Alerts: %0d, saturated idle counts: %0d, input stalls during hold-off: %0d.",
                 n_alerts, n_saturated, n_in_stalls);
        if (errors == 0) begin
            $display("inactivity_reminder_timer verification clean");
        end else begin
            $display("%0d mismatches found.", errors);
            $display("inactivity_reminder_timer verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
+incdir+src
src/irt_pkg.sv
src/irt_core.sv
src/inactivity_reminder_timer.sv
src/irt_checker.sv
test/testbench.sv
